/* design/tst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg - shared types and constants of the timer slot table
// Field widths, operation and status codes, and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int SLOTS   = 32;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ID_W    = 16;
	localparam int TIME_W  = 48;
	localparam int ENTRY_W = ID_W + TIME_W;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 3;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NONE      = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture the input word
		logic scan_clr;    // restart address counter and scan accumulators
		logic scan_issue;  // issue one table read and advance
		logic add_exec;    // place the new timer and emit its result
		logic finish;      // emit the result of a scan pass
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;   // read of the highest slot is being issued
		logic rescan;      // tick with more expired entries pending
	} stat_t;

endpackage

/* design/tst_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/tst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_ctrl - sequencer of the timer slot table
// Steps an add through its write, a remove or tick through one or more scans.
// ----------------------------------------------------------------------------
module tst_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tst_pkg::MODE_W-1:0]  mode,
	input  tst_pkg::stat_t              stat,
	output tst_pkg::cmd_t               cmd,
	output logic                        busy
);

	import tst_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ADD    = 5'b00010,
		S_SCAN   = 5'b00100,
		S_LAST   = 5'b01000,
		S_DECIDE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					case (mode)
						MODE_ADD:    state_d = S_ADD;
						MODE_REMOVE: state_d = S_SCAN;
						MODE_TICK:   state_d = S_SCAN;
						default:     state_d = S_IDLE; // unused code: drop
					endcase
				end
			end
			S_ADD: begin
				cmd.add_exec = 1'b1;
				state_d      = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				// last read data is compared here
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.finish = 1'b1;
				if (stat.rescan) begin
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* design/tst_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_dp - datapath of the timer slot table
// Slot valid bits, entry RAM, scan pipeline, minimum tracker, result register.
// ----------------------------------------------------------------------------
module tst_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tst_pkg::cmd_t               cmd,
	output tst_pkg::stat_t              stat,
	input  logic [tst_pkg::MODE_W-1:0]  mode,
	input  logic [tst_pkg::ID_W-1:0]    timer_id,
	input  logic [tst_pkg::TIME_W-1:0]  deadline,
	input  logic [tst_pkg::TIME_W-1:0]  now,
	output logic                        strobe,
	output logic [tst_pkg::STAT_W-1:0]  status,
	output logic [tst_pkg::ID_W-1:0]    out_timer_id,
	output logic [tst_pkg::TIME_W-1:0]  out_deadline,
	output logic                        last
);

	import tst_pkg::*;

	// captured input word
	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] dl_q;
	logic [TIME_W-1:0] now_q;

	logic [SLOTS-1:0]  used_q;

	// scan pipeline
	logic [SLOT_W-1:0] addr_q;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;

	// scan accumulators
	logic              found_q;
	logic [SLOT_W-1:0] found_idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              best_vld_q;
	logic [TIME_W-1:0] best_exp_q;
	logic [ID_W-1:0]   best_id_q;
	logic [SLOT_W-1:0] best_idx_q;

	// result register
	logic              res_v_q;
	logic [STAT_W-1:0] res_st_q;
	logic [ID_W-1:0]   res_id_q;
	logic [TIME_W-1:0] res_dl_q;
	logic              res_last_q;

	logic [ENTRY_W-1:0] rdata;
	logic [ID_W-1:0]    rd_id;
	logic [TIME_W-1:0]  rd_exp;
	logic               free_any;
	logic [SLOT_W-1:0]  free_idx;
	logic               ram_we;
	logic               rm_hit;
	logic               pend;
	logic               better;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign ram_we = cmd.add_exec && free_any;

	tst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata ({id_q, dl_q}),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign rd_id  = rdata[ENTRY_W-1 -: ID_W];
	assign rd_exp = rdata[TIME_W-1:0];

	assign rm_hit = vld_s1 && (mode_q == MODE_REMOVE) && used_q[idx_s1]
		&& (rd_id == id_q) && !found_q;
	assign pend   = vld_s1 && (mode_q == MODE_TICK) && used_q[idx_s1]
		&& (rd_exp <= now_q);
	// strict compare keeps the lower slot on equal deadlines
	assign better = !best_vld_q || (rd_exp < best_exp_q);

	assign stat.scan_last = (addr_q == SLOT_W'(SLOTS - 1));
	assign stat.rescan    = (mode_q == MODE_TICK) && best_vld_q && (cnt_q != CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			id_q   <= timer_id;
			dl_q   <= deadline;
			now_q  <= now;
		end
		idx_s1 <= addr_q;
		if (rm_hit) begin
			found_idx_q <= idx_s1;
		end
		if (pend && better) begin
			best_exp_q <= rd_exp;
			best_id_q  <= rd_id;
			best_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			addr_q     <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			cnt_q      <= '0;
			best_vld_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_issue;
			if (cmd.scan_clr) begin
				addr_q     <= '0;
				found_q    <= 1'b0;
				cnt_q      <= '0;
				best_vld_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					addr_q <= addr_q + 1'b1;
				end
				if (rm_hit) begin
					found_q <= 1'b1;
				end
				if (pend) begin
					cnt_q      <= cnt_q + 1'b1;
					best_vld_q <= best_vld_q || better;
				end
			end
			if (ram_we) begin
				used_q[free_idx] <= 1'b1;
			end
			if (cmd.finish) begin
				if (mode_q == MODE_REMOVE) begin
					if (found_q) begin
						used_q[found_idx_q] <= 1'b0;
					end
				end else if (best_vld_q) begin
					used_q[best_idx_q] <= 1'b0;
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= cmd.add_exec || cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_exec) begin
			res_st_q   <= free_any ? ST_ADDED : ST_FULL;
			res_id_q   <= id_q;
			res_dl_q   <= '0;
			res_last_q <= 1'b1;
		end else if (cmd.finish) begin
			if (mode_q == MODE_REMOVE) begin
				res_st_q   <= found_q ? ST_REMOVED : ST_NOT_FOUND;
				res_id_q   <= id_q;
				res_dl_q   <= '0;
				res_last_q <= 1'b1;
			end else if (best_vld_q) begin
				res_st_q   <= ST_EXPIRED;
				res_id_q   <= best_id_q;
				res_dl_q   <= best_exp_q;
				res_last_q <= (cnt_q == CNT_W'(1));
			end else begin
				res_st_q   <= ST_NONE;
				res_id_q   <= '0;
				res_dl_q   <= '0;
				res_last_q <= 1'b1;
			end
		end
	end

	assign strobe       = res_v_q;
	assign status       = res_st_q;
	assign out_timer_id = res_id_q;
	assign out_deadline = res_dl_q;
	assign last         = res_last_q;

	a_expired_due: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && (res_st_q == ST_EXPIRED) |-> (res_dl_q <= now_q))
		else $error("expired word carries a deadline after now");

	a_cnt_best: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !best_vld_q)
		else $error("minimum tracker valid with no pending entry counted");

	a_add_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ram_we) |-> ($countones(used_q) == $countones($past(used_q)) + 1))
		else $error("add did not take exactly one slot");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && $past(vld_s1) |-> (idx_s1 == $past(idx_s1) + 1'b1))
		else $error("scan skipped a slot");

endmodule

/* design/timer_slot_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_table - fixed table of pending timers
// Add, remove and expire timers held in a table of SLOTS entries.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; results appear one per
// cycle-wide strobe and cannot be held off, so capture them as they come.
// An add writes its entry in S_ADD and then strobes its result. A remove
// scans the entry RAM one slot per cycle through its single read port and
// strobes its result after the S_LAST and S_DECIDE states. A tick runs one
// full scan pass for each expired entry it emits (one pass when none has
// expired); busy stays high until the last pass is done.
// Unused mode code three is taken and produces no result.
// ----------------------------------------------------------------------------
module timer_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tst_pkg::MODE_W-1:0]  mode,
	input  logic [tst_pkg::ID_W-1:0]    timer_id,
	input  logic [tst_pkg::TIME_W-1:0]  deadline,
	input  logic [tst_pkg::TIME_W-1:0]  now,
	output logic                        strobe,
	output logic [tst_pkg::STAT_W-1:0]  status,
	output logic [tst_pkg::ID_W-1:0]    out_timer_id,
	output logic [tst_pkg::TIME_W-1:0]  out_deadline,
	output logic                        last
);

	import tst_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.timer_id     (timer_id),
		.deadline     (deadline),
		.now          (now),
		.strobe       (strobe),
		.status       (status),
		.out_timer_id (out_timer_id),
		.out_deadline (out_deadline),
		.last         (last)
	);

endmodule

/* sim/timer_slot_table_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_table_check - result checker for the timer slot table
// Watches the command and result channels, runs its own copy of the slot
// table on every accepted word and compares each strobed result, field by
// field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module timer_slot_table_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [tst_pkg::MODE_W-1:0]  mode,
	input  logic [tst_pkg::ID_W-1:0]    timer_id,
	input  logic [tst_pkg::TIME_W-1:0]  deadline,
	input  logic [tst_pkg::TIME_W-1:0]  now,
	input  logic                        strobe,
	input  logic [tst_pkg::STAT_W-1:0]  status,
	input  logic [tst_pkg::ID_W-1:0]    out_timer_id,
	input  logic [tst_pkg::TIME_W-1:0]  out_deadline,
	input  logic                        last,
	output int                          errors,
	output int                          outstanding
);
	import tst_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] dl;
		logic              last;
	} timer_result_t;

	timer_result_t     due_results[$];
	logic              slot_busy[SLOTS];
	logic [ID_W-1:0]   slot_id[SLOTS];
	logic [TIME_W-1:0] slot_dl[SLOTS];

	task automatic queue_result(input logic [STAT_W-1:0] st, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] dl, input logic lst);
		timer_result_t r;
		r.status = st;
		r.id     = id;
		r.dl     = dl;
		r.last   = lst;
		due_results.push_back(r);
	endtask

	task automatic free_slot(input int s);
		slot_busy[s] = 1'b0;
		slot_id[s]   = '0;
		slot_dl[s]   = '0;
	endtask

	// Update the table for one word and queue the results it causes.
	task automatic table_step(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] t);
		logic hit[SLOTS];
		logic done;
		int   cnt;
		int   best;
		done = 1'b0;
		cnt  = 0;
		case (m)
			MODE_ADD: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!done && !slot_busy[i]) begin
						slot_busy[i] = 1'b1;
						slot_id[i]   = id;
						slot_dl[i]   = dl;
						done         = 1'b1;
					end
				end
				queue_result(done ? ST_ADDED : ST_FULL, id, '0, 1'b1);
			end
			MODE_REMOVE: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!done && slot_busy[i] && slot_id[i] == id) begin
						free_slot(i);
						done = 1'b1;
					end
				end
				queue_result(done ? ST_REMOVED : ST_NOT_FOUND, id, '0, 1'b1);
			end
			MODE_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					hit[i] = slot_busy[i] && slot_dl[i] <= t;
					if (hit[i])
						cnt++;
				end
				if (cnt == 0)
					queue_result(ST_NONE, '0, '0, 1'b1);
				// earliest deadline first, lower slot wins a tie
				for (int k = 0; k < cnt; k++) begin
					best = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (hit[i]) begin
							if (best < 0)
								best = i;
							else if (slot_dl[i] < slot_dl[best])
								best = i;
						end
					end
					hit[best] = 1'b0;
					queue_result(ST_EXPIRED, slot_id[best], slot_dl[best], k == cnt - 1);
					free_slot(best);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				free_slot(i);
			due_results.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			if (strobe) begin
				if (due_results.size() == 0) begin
					$error("unexpected result word: status %0d id %0h deadline %0h",
						status, out_timer_id, out_deadline);
					errors++;
				end else begin
					e = due_results.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						errors++;
					end
					if (out_timer_id !== e.id) begin
						$error("out_timer_id: expected %0h, got %0h", e.id, out_timer_id);
						errors++;
					end
					if (out_deadline !== e.dl) begin
						$error("out_deadline: expected %0h, got %0h", e.dl, out_deadline);
						errors++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						errors++;
					end
				end
			end
			if (start && !busy)
				table_step(mode, timer_id, deadline, now);
			outstanding = due_results.size();
		end
	end

endmodule

/* sim/timer_slot_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_table_test - testbench of the timer slot table
// Directed words for duplicate, missing and tied entries and time extremes,
// then three random phases of add, remove and tick traffic with varying gaps
// (two pack the table past full); the checker predicts and compares results.
// ----------------------------------------------------------------------------
module timer_slot_table_test;
	import tst_pkg::*;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [MODE_W-1:0] mode = MODE_ADD;
	logic [ID_W-1:0]   timer_id = '0;
	logic [TIME_W-1:0] deadline = '0;
	logic [TIME_W-1:0] now = '0;
	logic              busy;
	logic              strobe;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   out_timer_id;
	logic [TIME_W-1:0] out_deadline;
	logic              last;
	int                errors;
	int                outstanding;
	int                gap_pct = 0;
	logic [TIME_W-1:0] wall = '0;

	always #5 clk = ~clk;

	timer_slot_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.timer_id     (timer_id),
		.deadline     (deadline),
		.now          (now),
		.strobe       (strobe),
		.status       (status),
		.out_timer_id (out_timer_id),
		.out_deadline (out_deadline),
		.last         (last)
	);

	timer_slot_table_check chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.timer_id     (timer_id),
		.deadline     (deadline),
		.now          (now),
		.strobe       (strobe),
		.status       (status),
		.out_timer_id (out_timer_id),
		.out_deadline (out_deadline),
		.last         (last),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	function automatic logic [TIME_W-1:0] any_time();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	// mostly a small pool so removes hit and duplicates occur
	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return ID_W'($urandom_range(15));
		else if (r < 92)
			return ID_W'($urandom());
		else
			return (r < 96) ? '0 : '1;
	endfunction

	function automatic logic [TIME_W-1:0] pick_deadline();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return wall + TIME_W'($urandom_range(300));
		else if (r < 90)
			return any_time();
		else
			return (r < 95) ? '0 : TIME_MAX;
	endfunction

	// Present one word and hold it until taken; maybe idle afterwards.
	task automatic send_word(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] t);
		int gap;
		start    <= 1'b1;
		mode     <= m;
		timer_id <= id;
		deadline <= dl;
		now      <= t;
		do
			@(posedge clk);
		while (busy);
		if ($urandom_range(99) < gap_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every predicted result has come back.
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic random_phase(input int words, input int pct, input bit fill);
		int r;
		logic [TIME_W-1:0] t;
		gap_pct = pct;
		for (int n = 0; n < words; n++) begin
			// pack the table past full once
			if (fill && n == words / 2) begin
				for (int j = 0; j < SLOTS + 2; j++)
					send_word(MODE_ADD, pick_id(), pick_deadline(), any_time());
				continue;
			end
			r = $urandom_range(99);
			if (r < 40) begin
				send_word(MODE_ADD, pick_id(), pick_deadline(), any_time());
			end else if (r < 65) begin
				send_word(MODE_REMOVE, pick_id(), any_time(), any_time());
			end else if (r < 95) begin
				r = $urandom_range(99);
				if (r < 80) begin
					wall = wall + TIME_W'($urandom_range(150));
					t = wall;
				end else if (r < 90) begin
					t = any_time();
				end else begin
					t = (r < 95) ? '0 : TIME_MAX;
				end
				send_word(MODE_TICK, ID_W'($urandom()), any_time(), t);
			end else begin
				send_word(MODE_UNUSED, ID_W'($urandom()), any_time(), any_time());
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(MODE_TICK, '0, '0, '0);
		send_word(MODE_REMOVE, '0, '0, '0);
		send_word(MODE_ADD, '1, TIME_MAX, '0);
		send_word(MODE_ADD, '0, '0, TIME_MAX);
		send_word(MODE_ADD, 16'd5, 48'd100, '0);
		send_word(MODE_ADD, 16'd5, 48'd50, '0);
		send_word(MODE_ADD, 16'd7, 48'd100, '0);
		send_word(MODE_UNUSED, 16'h1234, any_time(), any_time());
		send_word(MODE_TICK, '0, TIME_MAX, '0);
		send_word(MODE_ADD, 16'd9, 48'd100, '0);
		send_word(MODE_REMOVE, 16'd5, '0, '0);
		// two entries tie at 100; the lower slot goes first
		send_word(MODE_TICK, '0, '0, 48'd100);
		send_word(MODE_REMOVE, 16'd5, '0, '0);
		send_word(MODE_TICK, '0, '0, TIME_MAX - 1);
		send_word(MODE_TICK, '0, '0, TIME_MAX);
		send_word(MODE_ADD, 16'hAAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
		send_word(MODE_ADD, 16'h5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
		send_word(MODE_REMOVE, 16'hAAAA, '0, '0);
		send_word(MODE_TICK, '0, '0, TIME_MAX);
		drain();

		random_phase(60, 10, 1'b1);
		drain();
		random_phase(60, 64, 1'b0);
		drain();
		random_phase(60, 0, 1'b1);
		drain();
		repeat (SLOTS + 8) @(posedge clk);

		if (errors == 0)
			$display("timer_slot_table: match");
		else
			$display("timer_slot_table: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("timer_slot_table: mismatch");
		$finish;
	end

endmodule
